// ----- design/idw_neighbor_interpolation_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour interpolation block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IDW_NEIGHBOR_INTERPOLATION_ASSERT_SVH
`define IDW_NEIGHBOR_INTERPOLATION_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IDWNI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idwni assertion failed");
// next-cycle implication
`define IDWNI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idwni assertion failed");
`else
`define IDWNI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IDWNI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/idwni_pkg.sv -----
// ----------------------------------------------------------------------------
// idwni_pkg
// Shared constants, codes and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package idwni_pkg;

    localparam int MAX_NEIGHBORS = 64;
    localparam int CNT_WIDTH     = 7;
    localparam int CNT_LIMIT     = (MAX_NEIGHBORS < 127) ? MAX_NEIGHBORS : 127;

    localparam logic signed [31:0] NONE_VALUE  = -32'sd65470464;
    localparam logic [63:0]        WEIGHT_INIT = 64'h0000_0100_0000_0000;
    localparam logic [63:0]        WEIGHT_CAP  = 64'h4000_0000_0000_0000;

    localparam logic [29:0] HEIGHT_GAP_RESET = 30'h3FFF_FFFF;
    localparam logic [30:0] MAX_DIST_RESET   = 31'h7FFF_FFFF;
    localparam logic [30:0] MIN_DIST_RESET   = 31'h0;
    localparam logic [3:0]  POWER_RESET      = 4'd2;

    localparam logic [6:0] SQRT_STEPS = 7'd32;
    localparam logic [6:0] WDIV_STEPS = 7'd79;
    localparam logic [6:0] QDIV_STEPS = 7'd96;

    typedef enum logic [1:0] {
        CFG_HEIGHT_GAP = 2'd0,
        CFG_MAX_DIST   = 2'd1,
        CFG_MIN_DIST   = 2'd2,
        CFG_POWER      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_MEAN  = 2'd0,
        STATUS_EXACT = 2'd1,
        STATUS_NONE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        MUL_SQX,
        MUL_SQY,
        MUL_SQZ,
        MUL_WHI,
        MUL_WLO
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sq_add;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     div_cap;
        logic     hold_hi;
        logic     acc;
        logic     quo_init;
        logic     quo_step;
        logic     res_load;
        status_t  res_sel;
        logic     set_finished;
        logic     clear;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic       finished;
        logic       last;
        logic       has;
        logic       keep;
        logic       far;
        logic       exact;
        logic       room;
        logic       empty;
        logic [3:0] power;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/idwni_dp.sv -----
// ----------------------------------------------------------------------------
// idwni_dp
// Datapath: capture, distance, weight divider, multiplier, totals, quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module idwni_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  idwni_pkg::cmd_t     cmd,
    output idwni_pkg::stat_t    stat,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  wire  signed [31:0]  query_x,
    input  wire  signed [31:0]  query_y,
    input  wire  signed [31:0]  query_z,
    input  wire  signed [31:0]  query_height,
    input  wire  signed [31:0]  point_x,
    input  wire  signed [31:0]  point_y,
    input  wire  signed [31:0]  point_z,
    input  wire  signed [31:0]  point_height,
    input  wire                 height_known,
    input  wire  signed [31:0]  neighbor_value,
    input  wire                 has_point,
    input  wire                 last_neighbor,
    output logic signed [31:0]  interp_value,
    output logic [1:0]          status
);

    logic [29:0] gap_reg;
    logic [30:0] max_reg;
    logic [30:0] min_reg;
    logic [3:0]  power_reg;

    logic [32:0]        adx_reg, ady_reg, adz_reg;
    logic signed [31:0] value_reg;
    logic               keep_reg, has_reg, last_reg;
    logic [63:0]        prod_reg, sum_reg;
    logic [63:0]        sx_reg, sr_reg, sbit_reg;
    logic [63:0]        w_reg, wq_reg, hi_reg;
    logic [78:0]        wn_reg;
    logic [31:0]        wrem_reg;
    logic               wbig_reg;
    logic [63:0]        wt_reg;
    logic signed [63:0] wvt_reg;
    logic [idwni_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic               fin_reg;
    logic [63:0]        qn_reg, qr_reg;
    logic [40:0]        qq_reg;
    logic               qbig_reg, qneg_reg;
    logic signed [31:0] res_value_reg, out_value_reg;
    logic [1:0]         res_status_reg, out_status_reg;

    // capture-time differences
    logic signed [32:0] dx, dy, dz, dh;
    logic [32:0]        adh;
    assign dx  = {point_x[31], point_x} - {query_x[31], query_x};
    assign dy  = {point_y[31], point_y} - {query_y[31], query_y};
    assign dz  = {point_z[31], point_z} - {query_z[31], query_z};
    assign dh  = {point_height[31], point_height} - {query_height[31], query_height};
    assign adh = dh[32] ? 33'(-dh) : 33'(dh);

    // shared multiplier
    logic [31:0] mul_a, mul_b, mag;
    logic        mul_sat;
    assign mag = value_reg[31] ? 32'(-value_reg) : 32'(value_reg);
    always_comb
    begin
        mul_a   = adx_reg[31:0];
        mul_b   = adx_reg[31:0];
        mul_sat = adx_reg[32];
        unique case (cmd.mul_sel)
            idwni_pkg::MUL_SQX: begin mul_a = adx_reg[31:0]; mul_b = adx_reg[31:0];
                                      mul_sat = adx_reg[32]; end
            idwni_pkg::MUL_SQY: begin mul_a = ady_reg[31:0]; mul_b = ady_reg[31:0];
                                      mul_sat = ady_reg[32]; end
            idwni_pkg::MUL_SQZ: begin mul_a = adz_reg[31:0]; mul_b = adz_reg[31:0];
                                      mul_sat = adz_reg[32]; end
            idwni_pkg::MUL_WHI: begin mul_a = w_reg[63:32]; mul_b = mag; mul_sat = 1'b0; end
            idwni_pkg::MUL_WLO: begin mul_a = w_reg[31:0];  mul_b = mag; mul_sat = 1'b0; end
            default:            begin mul_a = '0; mul_b = '0; mul_sat = 1'b0; end
        endcase
    end

    logic [64:0] sum_ext;
    assign sum_ext = {1'b0, sum_reg} + {1'b0, prod_reg};

    // square root step
    logic [63:0] st;
    assign st = sr_reg + sbit_reg;

    logic [31:0] distance;
    assign distance = sr_reg[31:0];

    // weight division step
    logic [32:0] wrs;
    logic        wge;
    assign wrs = {wrem_reg, wn_reg[78]};
    assign wge = wrs >= {1'b0, distance};

    // accumulate
    logic [63:0] c_val;
    logic [64:0] wvt_ext, wt_ext;
    assign c_val   = hi_reg + {32'b0, prod_reg[63:32]};
    assign wvt_ext = value_reg[31] ? ({wvt_reg[63], wvt_reg} - {1'b0, c_val})
                                   : ({wvt_reg[63], wvt_reg} + {1'b0, c_val});
    assign wt_ext  = {1'b0, wt_reg} + {1'b0, w_reg};

    // quotient step
    logic [63:0] qrs;
    logic        qge;
    assign qrs = {qr_reg[62:0], qn_reg[63]};
    assign qge = qr_reg[63] || (qrs >= wt_reg);

    logic signed [31:0] mean_value;
    always_comb
    begin
        if (qneg_reg)
            mean_value = (qbig_reg || qq_reg > 41'h0_8000_0000) ? 32'sh8000_0000
                                                                : 32'(-qq_reg[31:0]);
        else
            mean_value = (qbig_reg || qq_reg > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                                : 32'(qq_reg[31:0]);
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= idwni_pkg::HEIGHT_GAP_RESET;
            max_reg   <= idwni_pkg::MAX_DIST_RESET;
            min_reg   <= idwni_pkg::MIN_DIST_RESET;
            power_reg <= idwni_pkg::POWER_RESET;
            wt_reg    <= '0;
            wvt_reg   <= '0;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    idwni_pkg::CFG_HEIGHT_GAP: gap_reg   <= cfg_data[29:0];
                    idwni_pkg::CFG_MAX_DIST:   max_reg   <= cfg_data[30:0];
                    idwni_pkg::CFG_MIN_DIST:   min_reg   <= cfg_data[30:0];
                    idwni_pkg::CFG_POWER:      power_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.acc)
            begin
                if (wvt_ext[64] != wvt_ext[63])
                    wvt_reg <= value_reg[31] ? 64'sh8000_0000_0000_0000
                                             : 64'sh7FFF_FFFF_FFFF_FFFF;
                else
                    wvt_reg <= wvt_ext[63:0];
                wt_reg  <= wt_ext[64] ? '1 : wt_ext[63:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.set_finished)
                fin_reg <= 1'b1;
            if (cmd.clear)
            begin
                wt_reg  <= '0;
                wvt_reg <= '0;
                cnt_reg <= '0;
                fin_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            adx_reg   <= dx[32] ? 33'(-dx) : 33'(dx);
            ady_reg   <= dy[32] ? 33'(-dy) : 33'(dy);
            adz_reg   <= dz[32] ? 33'(-dz) : 33'(dz);
            value_reg <= neighbor_value;
            keep_reg  <= (neighbor_value > idwni_pkg::NONE_VALUE) && height_known
                         && (adh <= {2'b0, gap_reg, 1'b0});
            has_reg   <= has_point;
            last_reg  <= last_neighbor;
            sum_reg   <= '0;
            w_reg     <= idwni_pkg::WEIGHT_INIT;
        end
        if (cmd.mul_en)
            prod_reg <= mul_sat ? '1 : 64'(mul_a) * 64'(mul_b);
        if (cmd.sq_add)
            sum_reg <= sum_ext[64] ? '1 : sum_ext[63:0];
        if (cmd.sqrt_init)
        begin
            sx_reg   <= sum_reg;
            sr_reg   <= '0;
            sbit_reg <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (sx_reg >= st)
            begin
                sx_reg <= sx_reg - st;
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end
            else
                sr_reg <= sr_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            wn_reg   <= {w_reg[62:0], 16'b0};
            wrem_reg <= '0;
            wq_reg   <= '0;
            wbig_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            wrem_reg <= wge ? 32'(wrs - {1'b0, distance}) : wrs[31:0];
            wn_reg   <= {wn_reg[77:0], 1'b0};
            wq_reg   <= {wq_reg[62:0], wge};
            wbig_reg <= wbig_reg | wq_reg[63];
        end
        if (cmd.div_cap)
            w_reg <= (wbig_reg || wq_reg > idwni_pkg::WEIGHT_CAP) ? idwni_pkg::WEIGHT_CAP
                                                                  : wq_reg;
        if (cmd.hold_hi)
            hi_reg <= prod_reg;
        if (cmd.quo_init)
        begin
            qn_reg   <= wvt_reg[63] ? 64'(-wvt_reg) : 64'(wvt_reg);
            qneg_reg <= wvt_reg[63];
            qr_reg   <= '0;
            qq_reg   <= '0;
            qbig_reg <= 1'b0;
        end
        if (cmd.quo_step)
        begin
            qn_reg   <= {qn_reg[62:0], 1'b0};
            qr_reg   <= qge ? (qrs - wt_reg) : qrs;
            qq_reg   <= {qq_reg[39:0], qge};
            qbig_reg <= qbig_reg | qq_reg[40];
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_sel;
            unique case (cmd.res_sel)
                idwni_pkg::STATUS_EXACT: res_value_reg <= value_reg;
                idwni_pkg::STATUS_NONE:  res_value_reg <= idwni_pkg::NONE_VALUE;
                default:                 res_value_reg <= mean_value;
            endcase
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign interp_value = out_value_reg;
    assign status       = out_status_reg;

    assign stat.finished = fin_reg;
    assign stat.last     = last_reg;
    assign stat.has      = has_reg;
    assign stat.keep     = keep_reg;
    assign stat.far      = distance > {1'b0, max_reg};
    assign stat.exact    = (distance == '0) || (distance < {1'b0, min_reg});
    assign stat.room     = cnt_reg < idwni_pkg::CNT_WIDTH'(idwni_pkg::CNT_LIMIT);
    assign stat.empty    = (cnt_reg == '0) || (wt_reg == '0);
    assign stat.power    = power_reg;

endmodule

`default_nettype wire

// ----- design/idwni_ctrl.sv -----
// ----------------------------------------------------------------------------
// idwni_ctrl
// Sequencer for one neighbour: distance, weight, accumulate, final quotient.
// ----------------------------------------------------------------------------
`default_nettype none
`include "idw_neighbor_interpolation_assert.svh"

module idwni_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire               out_stall,
    input  idwni_pkg::stat_t  stat,
    output idwni_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_SQ, ST_SQI, ST_SQRT, ST_DCHK, ST_POW, ST_DIV,
        ST_CAP, ST_MUL0, ST_MUL1, ST_ACC, ST_TAIL, ST_QUO, ST_QEND, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [3:0] pk_reg, pk_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pk_next    = pk_reg;
        ov_next    = (ov_reg && !out_stall) ? 1'b0 : ov_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                priority if (stat.finished)
                begin
                    cmd.clear  = stat.last;
                    state_next = ST_IDLE;
                end
                else if (stat.has && stat.keep)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                    state_next = ST_TAIL;
            end
            ST_SQ:
            begin
                // multiply one axis while adding the previous square
                cmd.mul_en = cnt_reg < 7'd3;
                cmd.sq_add = cnt_reg != 7'd0;
                unique case (cnt_reg[1:0])
                    2'd0:    cmd.mul_sel = idwni_pkg::MUL_SQX;
                    2'd1:    cmd.mul_sel = idwni_pkg::MUL_SQY;
                    default: cmd.mul_sel = idwni_pkg::MUL_SQZ;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd3)
                    state_next = ST_SQI;
            end
            ST_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == idwni_pkg::SQRT_STEPS - 1'b1)
                    state_next = ST_DCHK;
            end
            ST_DCHK:
            begin
                priority if (stat.far)
                    state_next = ST_TAIL;
                else if (stat.exact)
                begin
                    cmd.res_load     = 1'b1;
                    cmd.res_sel      = idwni_pkg::STATUS_EXACT;
                    cmd.clear        = stat.last;
                    cmd.set_finished = !stat.last;
                    state_next       = ST_EMIT;
                end
                else if (stat.room)
                begin
                    pk_next    = '0;
                    state_next = ST_POW;
                end
                else
                    state_next = ST_TAIL;
            end
            ST_POW:
            begin
                if (pk_reg == stat.power)
                    state_next = ST_MUL0;
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == idwni_pkg::WDIV_STEPS - 1'b1)
                    state_next = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.div_cap = 1'b1;
                pk_next     = pk_reg + 1'b1;
                state_next  = ST_POW;
            end
            ST_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = idwni_pkg::MUL_WHI;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = idwni_pkg::MUL_WLO;
                cmd.hold_hi = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                priority if (!stat.last)
                    state_next = ST_IDLE;
                else if (stat.empty)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = idwni_pkg::STATUS_NONE;
                    cmd.clear    = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.quo_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_QUO;
                end
            end
            ST_QUO:
            begin
                cmd.quo_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == idwni_pkg::QDIV_STEPS - 1'b1)
                    state_next = ST_QEND;
            end
            ST_QEND:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = idwni_pkg::STATUS_MEAN;
                cmd.clear    = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pk_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pk_reg    <= pk_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = ov_reg;

    `IDWNI_ASSERT_NXT(a_emit_loads, clk, rst_n, state_reg == ST_EMIT && !(ov_reg && out_stall), ov_reg && state_reg == ST_IDLE)
    `IDWNI_ASSERT_NXT(a_accept_pre, clk, rst_n, in_valid && !in_stall, state_reg == ST_PRE)
    `IDWNI_ASSERT_IMP(a_sqrt_bound, clk, rst_n, state_reg == ST_SQRT, cnt_reg < idwni_pkg::SQRT_STEPS)

endmodule

`default_nettype wire

// ----- design/idw_neighbor_interpolation.sv -----
// ----------------------------------------------------------------------------
// idw_neighbor_interpolation
// Inverse distance weighted interpolation over a stream of neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one neighbour per transfer,
//   together with the query point; last_neighbor closes the query and an item
//   with has_point low carries no neighbour. The output channel
//   (out_valid / out_stall) carries at most one result per query: the
//   weighted mean, an exact neighbour value (distance below min_distance or
//   zero), or status none with value -999.0.
//   Configuration registers are written on the cfg channel (cfg_ready is
//   always high); write them only while no item is in flight.
//   Per item: once the query has ended on an exact hit, items are dropped;
//   a skipped neighbour goes straight to the tail; rejecting one on distance
//   or returning an exact hit runs the 32-step square root, and an accumulated
//   one also runs the one-bit-a-cycle weight divider p times. A last item with
//   non-empty totals runs 96 quotient steps, forms the result and hands it on.
//   One item is in work at a time; a waiting result sits in the output
//   register and the next item is taken meanwhile, but a new result is held
//   until the previous transfer completes.
//   Reset clears the totals, the query state, the output valid and restores
//   the register defaults; out_stall simply holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module idw_neighbor_interpolation (
    input  wire                clk,
    input  wire                rst_n,
    // neighbour input channel
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  signed [31:0] query_x,
    input  wire  signed [31:0] query_y,
    input  wire  signed [31:0] query_z,
    input  wire  signed [31:0] query_height,
    input  wire  signed [31:0] point_x,
    input  wire  signed [31:0] point_y,
    input  wire  signed [31:0] point_z,
    input  wire  signed [31:0] point_height,
    input  wire                height_known,
    input  wire  signed [31:0] neighbor_value,
    input  wire                has_point,
    input  wire                last_neighbor,
    // result channel
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [31:0] interp_value,
    output logic [1:0]         status,
    // configuration write channel
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [1:0]         cfg_index,
    input  wire  [31:0]        cfg_data
);

    idwni_pkg::cmd_t  cmd;
    idwni_pkg::stat_t stat;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    idwni_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    idwni_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .query_x        (query_x),
        .query_y        (query_y),
        .query_z        (query_z),
        .query_height   (query_height),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_height   (point_height),
        .height_known   (height_known),
        .neighbor_value (neighbor_value),
        .has_point      (has_point),
        .last_neighbor  (last_neighbor),
        .interp_value   (interp_value),
        .status         (status)
    );

endmodule

`default_nettype wire
